FILE: design/lane_aligned_replica_merger_unit_defines.svh
// ----------------------------------------------------------------------------
// Lane-aligned replica merger assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LANE_ALIGNED_REPLICA_MERGER_UNIT_DEFINES_SVH
`define LANE_ALIGNED_REPLICA_MERGER_UNIT_DEFINES_SVH

`define LRM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define LRM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lrm_pkg.sv
// ----------------------------------------------------------------------------
// Lane-aligned replica merger package
// Field widths, register indexes, reset values, shared types and the ring index step.
// ----------------------------------------------------------------------------
package lrm_pkg;

  localparam int LANE_W     = 2;
  localparam int PKT_ID_W   = 16;
  localparam int PAINT_W    = 8;
  localparam int OUT_ID_W   = 16;
  localparam int DROP_W     = 32;
  localparam int CAP_W      = 5;
  localparam int IDX_W      = 5;
  localparam int MOD_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP     = 2'd1;

  localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd31;
  localparam logic [PAINT_W-1:0] SKIP_RESET = 8'd10;

  typedef struct packed {
    logic [CAP_W-1:0]   capacity;
    logic [PAINT_W-1:0] skip_paint;
    logic               clear;
  } lrm_cfg_t;

  typedef struct packed {
    logic                out_valid;
    logic [OUT_ID_W-1:0] out_id;
    logic                accepted;
    logic [DROP_W-1:0]   drop_count;
    logic                last;
  } lrm_res_t;

  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                  input logic [MOD_W-1:0] modulus);
    logic [MOD_W-1:0] inc;
    inc = {1'b0, idx} + MOD_W'(1);
    return (inc == modulus) ? '0 : inc[IDX_W-1:0];
  endfunction

endpackage

FILE: design/lane_aligned_replica_merger_unit.sv
// ----------------------------------------------------------------------------
// Lane-aligned replica merger unit
// An arrival on a lane other than 0 passes S_ENQ and S_FINAL to its single result.
// An arrival on lane 0 also passes S_CHECK and runs dequeue rounds (S_RD per lane,
// S_RLAST, S_RDONE), paced by the single read port of the ring memory, one lane per cycle.
// Asynchronous low reset empties all rings and clears the drop counters.
// ----------------------------------------------------------------------------
`include "lane_aligned_replica_merger_unit_defines.svh"

module lane_aligned_replica_merger_unit #(
  parameter int LANES    = 4,
  parameter int SLOTS    = 32,
  parameter int ID_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lrm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lrm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lrm_pkg::LANE_W-1:0]      lane_i,
  input  logic [lrm_pkg::PKT_ID_W-1:0]    packet_id_i,
  input  logic [lrm_pkg::PAINT_W-1:0]     paint_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic                            out_valid_o,
  output logic [lrm_pkg::OUT_ID_W-1:0]    out_id_o,
  output logic                            accepted_o,
  output logic [lrm_pkg::DROP_W-1:0]      drop_count_o,
  output logic                            last_o
);
  import lrm_pkg::*;

  localparam int LW     = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int AW     = $clog2(SLOTS);
  localparam int DATA_W = ID_WIDTH + PAINT_W;

  logic [CAP_W-1:0]   cap_q;
  logic [PAINT_W-1:0] skip_q;
  lrm_cfg_t           cfg;
  lrm_res_t           res;
  lrm_res_t           res_q;
  logic               res_valid_q;
  logic               out_free;
  logic               emit;
  logic               mem_we;
  logic [LW+AW-1:0]   mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [LW+AW-1:0]   mem_raddr;
  logic [DATA_W-1:0]  mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      skip_q <= SKIP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CAPACITY: cap_q  <= cfg_data_i[CAP_W-1:0];
        CFG_SKIP:     skip_q <= cfg_data_i[PAINT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.capacity   = cap_q;
  assign cfg.skip_paint = skip_q;
  assign cfg.clear      = cfg_we_i && (cfg_index_i == CFG_CAPACITY);

  assign out_free = !res_valid_q || res_ready_i;

  lrm_ctrl #(
    .LANES    (LANES),
    .SLOTS    (SLOTS),
    .ID_WIDTH (ID_WIDTH),
    .LW       (LW),
    .AW       (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .lane_i      (lane_i),
    .packet_id_i (packet_id_i),
    .paint_i     (paint_i),
    .out_free_i  (out_free),
    .emit_o      (emit),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  lrm_ring_mem #(
    .ADDR_W (LW + AW),
    .DATA_W (DATA_W)
  ) u_ring_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (emit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign out_valid_o  = res_q.out_valid;
  assign out_id_o     = res_q.out_id;
  assign accepted_o   = res_q.accepted;
  assign drop_count_o = res_q.drop_count;
  assign last_o       = res_q.last;

  `LRM_ASSERT_NXT(a_busy_after_request, in_valid_i && in_ready_o, !in_ready_o, "request not held off")
  `LRM_ASSERT_IMP(a_empty_is_last, res_valid_o && !out_valid_o, last_o, "empty result not last")
  `LRM_ASSERT_IMP(a_empty_id_zero, res_valid_o && !out_valid_o, out_id_o == '0, "empty result has id")

endmodule

FILE: design/lrm_ring_mem.sv
// ----------------------------------------------------------------------------
// Ring descriptor memory
// One write port and one registered read port over all lanes' rings.
// ----------------------------------------------------------------------------
module lrm_ring_mem #(
  parameter int ADDR_W = 7,
  parameter int DATA_W = 24
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lrm_ctrl.sv
// ----------------------------------------------------------------------------
// Merger sequencer
// Enqueues arrivals, keeps ring indices and drop counts, and runs the
// dequeue rounds against the ring memory one lane per cycle.
// ----------------------------------------------------------------------------
module lrm_ctrl #(
  parameter int LANES    = 4,
  parameter int SLOTS    = 32,
  parameter int ID_WIDTH = 16,
  parameter int LW       = 2,
  parameter int AW       = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lrm_pkg::lrm_cfg_t             cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lrm_pkg::LANE_W-1:0]    lane_i,
  input  logic [lrm_pkg::PKT_ID_W-1:0]  packet_id_i,
  input  logic [lrm_pkg::PAINT_W-1:0]   paint_i,
  input  logic                          out_free_i,
  output logic                          emit_o,
  output lrm_pkg::lrm_res_t             res_o,
  output logic                          mem_we_o,
  output logic [LW+AW-1:0]              mem_waddr_o,
  output logic [ID_WIDTH+lrm_pkg::PAINT_W-1:0] mem_wdata_o,
  output logic                          mem_re_o,
  output logic [LW+AW-1:0]              mem_raddr_o,
  input  logic [ID_WIDTH+lrm_pkg::PAINT_W-1:0] mem_rdata_i
);
  import lrm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ENQ, S_CHECK, S_RD, S_RLAST, S_RDONE, S_FINAL
  } state_e;

  state_e               state_q;
  logic [LANE_W-1:0]    lane_q;
  logic [ID_WIDTH-1:0]  id_q;
  logic [PAINT_W-1:0]   paint_q;
  logic                 acc_q;
  logic [DROP_W-1:0]    drops_out_q;
  logic [LW-1:0]        k_q;
  logic                 rd_v_q;
  logic                 have_q;
  logic [ID_WIDTH-1:0]  fwd_q;
  logic                 pend_q;
  logic [ID_WIDTH-1:0]  pend_id_q;
  logic [IDX_W-1:0]     head_q [LANES];
  logic [IDX_W-1:0]     tail_q [LANES];
  logic [DROP_W-1:0]    drops_q [LANES];

  logic [8:0]           mod_wide;
  logic [8:0]           mod_lim;
  logic [MOD_W-1:0]     ring_mod;
  logic [LW-1:0]        lidx;
  logic [LW-1:0]        hsel;
  logic                 lane_ok;
  logic [IDX_W-1:0]     tail_sel;
  logic [IDX_W-1:0]     head_sel;
  logic [IDX_W-1:0]     tail_nx;
  logic                 full;
  logic [DROP_W-1:0]    drop_cur;
  logic [DROP_W-1:0]    drop_nx;
  logic                 all_ready;
  logic                 k_last;
  logic [PAINT_W-1:0]   rd_paint;
  logic [ID_WIDTH-1:0]  rd_id;

  assign mod_wide = 9'(cfg_i.capacity) + 9'd1;
  assign mod_lim  = (32'(mod_wide) > SLOTS) ? 9'(SLOTS) : mod_wide;
  assign ring_mod = mod_lim[MOD_W-1:0];

  assign lidx     = LW'(lane_q);
  assign lane_ok  = 32'(lane_q) < LANES;
  assign hsel     = (state_q == S_RD) ? k_q : lidx;
  assign tail_sel = tail_q[lidx];
  assign head_sel = head_q[hsel];
  assign tail_nx  = next_index(tail_sel, ring_mod);
  assign full     = (tail_nx == head_sel);
  assign drop_cur = drops_q[lidx];
  assign drop_nx  = (drop_cur == {DROP_W{1'b1}}) ? drop_cur : drop_cur + DROP_W'(1);
  assign k_last   = (32'(k_q) == LANES - 1);
  assign rd_paint = mem_rdata_i[ID_WIDTH +: PAINT_W];
  assign rd_id    = mem_rdata_i[ID_WIDTH-1:0];

  always_comb begin
    all_ready = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      if (head_q[i] == tail_q[i]) begin
        all_ready = 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign mem_we_o    = (state_q == S_ENQ) && lane_ok && !full;
  assign mem_waddr_o = {lidx, AW'(tail_sel)};
  assign mem_wdata_o = {paint_q, id_q};
  assign mem_re_o    = (state_q == S_RD);
  assign mem_raddr_o = {k_q, AW'(head_sel)};

  assign emit_o = out_free_i &&
                  ((state_q == S_FINAL) || (state_q == S_RDONE && have_q && pend_q));

  always_comb begin
    res_o.out_valid  = pend_q;
    res_o.out_id     = pend_q ? OUT_ID_W'(pend_id_q) : '0;
    res_o.accepted   = acc_q;
    res_o.drop_count = drops_out_q;
    res_o.last       = (state_q == S_FINAL);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      lane_q  <= lane_i;
      id_q    <= ID_WIDTH'(packet_id_i);
      paint_q <= paint_i;
    end
    if (rd_v_q && !have_q && rd_paint != cfg_i.skip_paint) begin
      fwd_q <= rd_id;
    end
    if (state_q == S_RDONE && have_q && (!pend_q || out_free_i)) begin
      pend_id_q <= fwd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= 1'b0;
      drops_out_q <= '0;
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      have_q      <= 1'b0;
      pend_q      <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        drops_q[i] <= '0;
      end
    end else begin
      rd_v_q <= (state_q == S_RD);
      if (rd_v_q && !have_q && rd_paint != cfg_i.skip_paint) begin
        have_q <= 1'b1;
      end
      if (cfg_i.clear) begin
        for (int i = 0; i < LANES; i++) begin
          head_q[i] <= '0;
          tail_q[i] <= '0;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_ENQ;
          end
        end
        S_ENQ: begin
          if (!lane_ok) begin
            acc_q       <= 1'b0;
            drops_out_q <= '0;
            state_q     <= S_FINAL;
          end else begin
            if (!full) begin
              tail_q[lidx] <= tail_nx;
              acc_q        <= 1'b1;
              drops_out_q  <= drop_cur;
            end else begin
              drops_q[lidx] <= drop_nx;
              acc_q         <= 1'b0;
              drops_out_q   <= drop_nx;
            end
            state_q <= (lane_q == '0) ? S_CHECK : S_FINAL;
          end
        end
        S_CHECK: begin
          if (all_ready) begin
            k_q     <= '0;
            have_q  <= 1'b0;
            state_q <= S_RD;
          end else begin
            state_q <= S_FINAL;
          end
        end
        S_RD: begin
          head_q[k_q] <= next_index(head_sel, ring_mod);
          if (k_last) begin
            state_q <= S_RLAST;
          end else begin
            k_q <= k_q + LW'(1);
          end
        end
        S_RLAST: begin
          state_q <= S_RDONE;
        end
        S_RDONE: begin
          if (!have_q) begin
            state_q <= S_CHECK;
          end else if (!pend_q || out_free_i) begin
            pend_q  <= 1'b1;
            state_q <= S_CHECK;
          end
        end
        S_FINAL: begin
          if (out_free_i) begin
            pend_q  <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Lane-aligned replica merger testbench
// Sends descriptor requests with random gaps and random result stalls,
// predicts every result from a private copy of the rings, drop counters and
// registers, and compares each result field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrm_pkg::*;

  localparam int LANES          = 4;
  localparam int SLOTS          = 32;
  localparam int ID_WIDTH       = 16;
  localparam int TOTAL_REQUESTS = 500;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE1 = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [LANE_W-1:0]     lane_i;
  logic [PKT_ID_W-1:0]   packet_id_i;
  logic [PAINT_W-1:0]    paint_i;
  logic                  res_valid_o;
  logic                  res_ready_i;
  logic                  out_valid_o;
  logic [OUT_ID_W-1:0]   out_id_o;
  logic                  accepted_o;
  logic [DROP_W-1:0]     drop_count_o;
  logic                  last_o;

  logic [PAINT_W+PKT_ID_W-1:0] slot_mem [LANES][SLOTS];
  logic [IDX_W-1:0]            head_q [LANES];
  logic [IDX_W-1:0]            tail_q [LANES];
  logic [DROP_W-1:0]           drops_q [LANES];
  logic [CAP_W-1:0]            cap_q;
  logic [PAINT_W-1:0]          skip_q;

  lrm_res_t    awaited_results[$];
  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned requests_dropped;
  int unsigned results_checked;
  int unsigned forwards_checked;
  int unsigned reg_writes;
  int unsigned deepest_drain;
  bit          tx_steady;
  bit          rx_steady;

  lane_aligned_replica_merger_unit #(
    .LANES(LANES),
    .SLOTS(SLOTS),
    .ID_WIDTH(ID_WIDTH)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .lane_i(lane_i),
    .packet_id_i(packet_id_i),
    .paint_i(paint_i),
    .res_valid_o(res_valid_o),
    .res_ready_i(res_ready_i),
    .out_valid_o(out_valid_o),
    .out_id_o(out_id_o),
    .accepted_o(accepted_o),
    .drop_count_o(drop_count_o),
    .last_o(last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IDX_W-1:0] ring_advance(input logic [IDX_W-1:0] idx);
    int unsigned modulus;
    modulus = int'(cap_q) + 1;
    if (modulus > SLOTS) modulus = SLOTS;
    return IDX_W'((int'(idx) + 1) % modulus);
  endfunction

  function automatic logic [PAINT_W-1:0] draw_paint();
    if ($urandom_range(0, 99) < 40) return skip_q;
    return PAINT_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [PKT_ID_W-1:0] draw_id();
    return PKT_ID_W'($urandom());
  endfunction

  function automatic int field_differs(input string field, input logic [DROP_W-1:0] want,
                                       input logic [DROP_W-1:0] got);
    if (got === want) return 0;
    $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
    return 1;
  endfunction

  task automatic predict_arrival(input logic [LANE_W-1:0] lane,
                                 input logic [PKT_ID_W-1:0] id,
                                 input logic [PAINT_W-1:0] paint);
    logic [IDX_W-1:0]            nxt;
    logic [PAINT_W+PKT_ID_W-1:0] entry;
    logic [OUT_ID_W-1:0]         fwd_ids[$];
    logic [OUT_ID_W-1:0]         fwd;
    logic                        acc;
    bit                          all_full;
    bit                          found;
    int unsigned                 rounds;
    nxt = ring_advance(tail_q[lane]);
    if (nxt != head_q[lane]) begin
      slot_mem[lane][tail_q[lane]] = {paint, id};
      tail_q[lane] = nxt;
      acc = 1'b1;
    end else begin
      if (drops_q[lane] != '1) drops_q[lane]++;
      acc = 1'b0;
      requests_dropped++;
    end
    rounds = 0;
    if (lane == 0) begin
      forever begin
        all_full = 1'b1;
        for (int ln = 0; ln < LANES; ln++) begin
          if (head_q[ln] == tail_q[ln]) all_full = 1'b0;
        end
        if (!all_full) break;
        found = 1'b0;
        fwd = '0;
        for (int ln = 0; ln < LANES; ln++) begin
          entry = slot_mem[ln][head_q[ln]];
          head_q[ln] = ring_advance(head_q[ln]);
          if (!found && entry[PKT_ID_W +: PAINT_W] != skip_q) begin
            found = 1'b1;
            fwd = OUT_ID_W'(entry[PKT_ID_W-1:0]);
          end
        end
        if (found) fwd_ids.push_back(fwd);
        rounds++;
      end
    end
    if (rounds > deepest_drain) deepest_drain = rounds;
    if (fwd_ids.size() == 0) begin
      awaited_results.push_back('{out_valid: 1'b0, out_id: '0, accepted: acc,
                                  drop_count: drops_q[lane], last: 1'b1});
    end else begin
      foreach (fwd_ids[i]) begin
        awaited_results.push_back('{out_valid: 1'b1, out_id: fwd_ids[i], accepted: acc,
                                    drop_count: drops_q[lane],
                                    last: (i == fwd_ids.size() - 1)});
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    lrm_res_t want;
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("Result with no request outstanding: out_valid %0d out_id 0x%0h",
               out_valid_o, out_id_o);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        error_count += field_differs("out_valid", want.out_valid, out_valid_o);
        error_count += field_differs("out_id", want.out_id, out_id_o);
        error_count += field_differs("accepted", want.accepted, accepted_o);
        error_count += field_differs("drop_count", want.drop_count, drop_count_o);
        error_count += field_differs("last", want.last, last_o);
        results_checked++;
        if (want.out_valid) forwards_checked++;
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    forever begin
      res_ready_i <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      stall = rx_steady ? 0 : idle_len();
      if (stall != 0) begin
        res_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input logic [LANE_W-1:0] lane, input logic [PKT_ID_W-1:0] id,
                           input logic [PAINT_W-1:0] paint);
    int unsigned gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    lane_i      <= lane;
    packet_id_i <= id;
    paint_i     <= paint;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
    predict_arrival(lane, id, paint);
  endtask

  task automatic wait_until_idle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_until_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_CAPACITY: begin
        cap_q = data[CAP_W-1:0];
        for (int ln = 0; ln < LANES; ln++) begin
          head_q[ln] = '0;
          tail_q[ln] = '0;
        end
      end
      CFG_SKIP: skip_q = data;
      default: ;
    endcase
  endtask

  // Lane 0 is filled first so that the closing lane 0 request drains depth rounds at once.
  task automatic send_round_set(input int unsigned depth);
    logic [LANE_W-1:0] order[$];
    int unsigned       pick;
    repeat (depth) send_item(LANE_W'(0), draw_id(), draw_paint());
    for (int j = 0; j < (LANES - 1) * depth; j++) order.push_back(LANE_W'(1 + j % (LANES - 1)));
    while (order.size() != 0) begin
      pick = $urandom_range(0, order.size() - 1);
      send_item(order[pick], draw_id(), draw_paint());
      order.delete(pick);
    end
    send_item(LANE_W'(0), draw_id(), draw_paint());
  endtask

  task automatic test_reset_defaults();
    send_item(LANE_W'(1), 16'hFFFF, skip_q);
    send_item(LANE_W'(2), 16'h0000, 8'hFF);
    send_item(LANE_W'(3), 16'h1234, 8'h00);
    send_item(LANE_W'(0), 16'h8000, skip_q);
    send_item(LANE_W'(1), 16'h00FF, skip_q);
    send_item(LANE_W'(2), 16'hFF00, skip_q);
    send_item(LANE_W'(3), 16'hAAAA, skip_q);
    send_item(LANE_W'(0), 16'h5555, skip_q);
  endtask

  task automatic test_ring_capacity();
    write_register(CFG_CAPACITY, 8'hE0);
    send_item(LANE_W'(0), 16'h0001, 8'h01);
    send_item(LANE_W'(3), 16'h0002, 8'h02);
    write_register(CFG_CAPACITY, 8'h27);
    for (int k = 0; k < 8; k++) send_item(LANE_W'(2), PKT_ID_W'(16'h2000 + k), PAINT_W'(k));
    send_item(LANE_W'(1), 16'h1001, 8'h80);
    send_item(LANE_W'(3), 16'h3001, 8'h7F);
    send_item(LANE_W'(0), 16'h0F0F, 8'h0A);
  endtask

  task automatic test_register_index();
    write_register(CFG_SPARE0, 8'h55);
    write_register(CFG_SPARE1, 8'hFF);
    write_register(CFG_CAPACITY, 8'h1F);
    write_register(CFG_SKIP, 8'h00);
    send_item(LANE_W'(1), 16'h7FFF, 8'h00);
    send_item(LANE_W'(2), 16'h0000, 8'h00);
    send_item(LANE_W'(3), 16'hFFFF, 8'hFF);
    send_item(LANE_W'(0), 16'hC3C3, 8'h00);
    write_register(CFG_SKIP, 8'hFF);
  endtask

  task automatic test_random_traffic();
    int unsigned           phase_end;
    int unsigned           pick;
    int unsigned           depth;
    logic [CFG_DATA_W-1:0] data;
    logic [LANE_W-1:0]     lane;
    bit                    first;
    first = 1'b1;
    while (requests_sent < TOTAL_REQUESTS) begin
      pick = $urandom_range(0, 11);
      data = CFG_DATA_W'($urandom_range(0, 255));
      if (first) data[CAP_W-1:0] = CAP_RESET;
      else if (pick == 0) data[CAP_W-1:0] = '0;
      else if (pick < 4) data[CAP_W-1:0] = 5'd7;
      else if (pick < 6) data[CAP_W-1:0] = 5'd31;
      else data[CAP_W-1:0] = CAP_W'($urandom_range(1, 31));
      write_register(CFG_CAPACITY, data);
      pick = $urandom_range(0, 3);
      if (pick == 0) write_register(CFG_SKIP, 8'h00);
      else if (pick == 1) write_register(CFG_SKIP, 8'hFF);
      else write_register(CFG_SKIP, CFG_DATA_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) begin
        write_register($urandom_range(0, 1) ? CFG_SPARE0 : CFG_SPARE1,
                       CFG_DATA_W'($urandom_range(0, 255)));
      end
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      if (first) begin
        send_round_set(CAP_RESET);
        first = 1'b0;
      end
      phase_end = requests_sent + $urandom_range(40, 80);
      while (requests_sent < phase_end && requests_sent < TOTAL_REQUESTS) begin
        pick = $urandom_range(0, 99);
        if (cap_q == 0 || pick < 15) begin
          repeat ($urandom_range(1, 6)) begin
            send_item(LANE_W'($urandom_range(0, LANES - 1)), draw_id(), draw_paint());
          end
        end else if (pick < 25 && cap_q <= 15) begin
          lane = LANE_W'($urandom_range(0, LANES - 1));
          repeat (int'(cap_q) + 2) send_item(lane, draw_id(), draw_paint());
        end else begin
          depth = $urandom_range(1, (cap_q < 5) ? int'(cap_q) : 5);
          send_round_set(depth);
        end
        if ($urandom_range(0, 9) == 0) wait_until_idle();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_CAPACITY;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    lane_i      <= '0;
    packet_id_i <= '0;
    paint_i     <= '0;
    cap_q = CAP_RESET;
    skip_q = SKIP_RESET;
    for (int ln = 0; ln < LANES; ln++) begin
      head_q[ln] = '0;
      tail_q[ln] = '0;
      drops_q[ln] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_ring_capacity();
    test_register_index();
    test_random_traffic();
    wait_until_idle();
    repeat (16) @(posedge clk_i);
    $display("Covered %0d requests (%0d dropped) and %0d register writes.",
             requests_sent, requests_dropped, reg_writes);
    $display("Checked %0d results, %0d forwarded; longest drain was %0d rounds.",
             results_checked, forwards_checked, deepest_drain);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/lrm_pkg.sv
design/lrm_ring_mem.sv
design/lrm_ctrl.sv
design/lane_aligned_replica_merger_unit.sv
tb/sv/tb.sv
